// ===== design/bsmm_pkg.sv =====
`timescale 1ns / 1ps

package bsmm_pkg;

   localparam int VALUE_W = 32;
   localparam int GAP_W   = 33;
   localparam int SIZE_W  = 33;
   localparam int WIDE_W  = 34;
   localparam int CAP_W   = 11;

   localparam logic [CAP_W-1:0] CAP_RESET    = 11'd1024;
   localparam logic [GAP_W-1:0] GAP_ALL_ONES = {GAP_W{1'b1}};

   localparam logic OP_SINGLE     = 1'b0;
   localparam logic OP_RANGE      = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] first_value;
      logic signed [VALUE_W-1:0] second_value;
   } req_payload_type;

   typedef struct packed {
      logic               status;
      logic [CAP_W-1:0]   element_count;
      logic               spans_valid;
      logic [VALUE_W-1:0] shortest_span;
      logic [VALUE_W-1:0] longest_span;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
   } interval_type;

   typedef struct packed {
      logic                      start;
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
      logic [GAP_W-1:0]          gap_init;
   } scan_cmd_type;

   typedef struct packed {
      logic             busy;
      logic [GAP_W-1:0] gap;
   } scan_stat_type;

endpackage

// ===== design/bsmm_if.sv =====
`timescale 1ns / 1ps

interface bsmm_req_if
   import bsmm_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bsmm_rsp_if
   import bsmm_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/bsmm_store.sv =====
`timescale 1ns / 1ps

module bsmm_store
   import bsmm_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  interval_type      wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output interval_type      rd_data
);

   interval_type mem [DEPTH];
   interval_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bsmm_scan.sv =====
`timescale 1ns / 1ps

// Walks stored intervals 0..count-1, one read per cycle, and folds the
// distance to the new interval into the running minimum gap.
module bsmm_scan
   import bsmm_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
)
(
   input  logic              clock,
   input  logic              reset,
   input  scan_cmd_type      cmd,
   input  logic [CNT_W-1:0]  count,
   output scan_stat_type     stat,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  interval_type      rd_data
);

   logic                      issuing_ff;
   logic                      rd_vld_ff;
   logic                      d_vld_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic [CNT_W-1:0]          idx_in;
   logic signed [VALUE_W-1:0] lo_ff;
   logic signed [VALUE_W-1:0] hi_ff;
   logic [VALUE_W-1:0]        d_ff;
   logic [VALUE_W-1:0]        d_in;
   logic [GAP_W-1:0]          gap_ff;
   logic [VALUE_W:0]          diff_above;
   logic [VALUE_W:0]          diff_below;

   assign idx_in  = idx_ff + CNT_W'(1);
   assign rd_en   = issuing_ff;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   assign diff_above = {rd_data.lo[VALUE_W-1], rd_data.lo} - {hi_ff[VALUE_W-1], hi_ff};
   assign diff_below = {lo_ff[VALUE_W-1], lo_ff} - {rd_data.hi[VALUE_W-1], rd_data.hi};

   always_comb begin
      if (hi_ff < rd_data.lo) begin
         d_in = diff_above[VALUE_W-1:0];
      end else if (rd_data.hi < lo_ff) begin
         d_in = diff_below[VALUE_W-1:0];
      end else begin
         d_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         d_vld_ff   <= 1'b0;
      end else begin
         if (cmd.start) begin
            issuing_ff <= (count != '0);
         end else if (issuing_ff && idx_in == count) begin
            issuing_ff <= 1'b0;
         end
         rd_vld_ff <= rd_en;
         d_vld_ff  <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff <= '0;
         lo_ff  <= cmd.lo;
         hi_ff  <= cmd.hi;
      end else if (issuing_ff) begin
         idx_ff <= idx_in;
      end
      d_ff <= d_in;
      if (cmd.start) begin
         gap_ff <= cmd.gap_init;
      end else if (d_vld_ff && {1'b0, d_ff} < gap_ff) begin
         gap_ff <= {1'b0, d_ff};
      end
   end

   assign stat.busy = issuing_ff | rd_vld_ff | d_vld_ff;
   assign stat.gap  = gap_ff;

endmodule

// ===== design/bounded_set_min_max_gap.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake           | Payload
// req_if   | in  | valid/ready         | operation, first_value, second_value
// rsp_if   | out | valid/ready         | status, element_count, spans_valid,
//          |     |                     | shortest_span, longest_span
// csr_*    | in  | csr_write_enable    | csr_write_data (capacity)
//
// An accepted insert loads its result after one memory read per stored interval; a
// rejected one skips the scan. One item is in flight; the next transfer is taken the
// cycle after loading. Reset is synchronous; memory contents need no clearing since
// only written entries are read. A stalled result is held in the output register
// while the next item transfer is taken.
module bounded_set_min_max_gap
   import bsmm_pkg::*;
#(
   parameter int DEPTH = 1024
)
(
   input  logic             clock,
   input  logic             reset,
   bsmm_req_if.sink         req_if,
   bsmm_rsp_if.source       rsp_if,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [WIDE_W-1:0] DEPTH_WIDE = WIDE_W'(DEPTH);
   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                state_ff;
   logic [2:0]                state_in;
   logic [CAP_W-1:0]          capacity_ff;
   logic                      op_ff;
   logic signed [VALUE_W-1:0] first_ff;
   logic signed [VALUE_W-1:0] second_ff;
   logic signed [VALUE_W-1:0] lo_ff;
   logic signed [VALUE_W-1:0] hi_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic                      status_ff;
   logic [CNT_W-1:0]          icount_ff;
   logic [CNT_W-1:0]          held_ff;
   logic signed [VALUE_W-1:0] smallest_ff;
   logic signed [VALUE_W-1:0] largest_ff;
   logic [GAP_W-1:0]          gap_ff;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff;

   logic signed [VALUE_W-1:0] other_end;
   logic signed [VALUE_W-1:0] lo_in;
   logic signed [VALUE_W-1:0] hi_in;
   logic [VALUE_W:0]          span_in;
   logic [WIDE_W-1:0]         cap_wide;
   logic [WIDE_W-1:0]         cap_eff;
   logic [WIDE_W-1:0]         held_wide;
   logic                      reject;
   logic [GAP_W-1:0]          gap_init;
   logic                      out_free;
   logic                      spans_valid;
   logic [CNT_W+CAP_W-1:0]    held_ext;

   scan_cmd_type              scan_cmd;
   scan_stat_type             scan_stat;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   interval_type              rd_data;
   logic                      wr_en;
   interval_type              wr_data;

   // operand ordering and range size
   assign other_end = (op_ff == OP_RANGE) ? second_ff : first_ff;
   assign lo_in     = (first_ff < other_end) ? first_ff : other_end;
   assign hi_in     = (first_ff < other_end) ? other_end : first_ff;
   assign span_in   = {hi_in[VALUE_W-1], hi_in} - {lo_in[VALUE_W-1], lo_in};

   // capacity check
   assign cap_wide  = WIDE_W'(capacity_ff);
   assign cap_eff   = (cap_wide > DEPTH_WIDE) ? DEPTH_WIDE : cap_wide;
   assign held_wide = WIDE_W'(held_ff);
   assign reject    = (held_wide > cap_eff) ||
                      (WIDE_W'(size_ff) > cap_eff - held_wide) ||
                      (icount_ff >= DEPTH_CNT);
   assign gap_init  = (size_ff > SIZE_W'(1) && gap_ff > GAP_W'(1)) ? GAP_W'(1) : gap_ff;

   assign scan_cmd.start    = (state_ff == ST_CHECK) && !reject;
   assign scan_cmd.lo       = lo_ff;
   assign scan_cmd.hi       = hi_ff;
   assign scan_cmd.gap_init = gap_init;

   assign wr_en      = (state_ff == ST_COMMIT);
   assign wr_data.lo = lo_ff;
   assign wr_data.hi = hi_ff;

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign spans_valid = (held_ff >= CNT_W'(2));
   assign held_ext    = {{CAP_W{1'b0}}, held_ff};

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = reject ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            if (!scan_stat.busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         icount_ff    <= '0;
         held_ff      <= '0;
         smallest_ff  <= '0;
         largest_ff   <= '0;
         gap_ff       <= GAP_ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (state_ff == ST_COMMIT) begin
            icount_ff <= icount_ff + CNT_W'(1);
            held_ff   <= held_ff + size_ff[CNT_W-1:0];
            gap_ff    <= scan_stat.gap;
            if (held_ff == '0 || lo_ff < smallest_ff) begin
               smallest_ff <= lo_ff;
            end
            if (held_ff == '0 || hi_ff > largest_ff) begin
               largest_ff <= hi_ff;
            end
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         op_ff     <= req_if.payload.operation;
         first_ff  <= req_if.payload.first_value;
         second_ff <= req_if.payload.second_value;
      end
      if (state_ff == ST_PREP) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         size_ff <= SIZE_W'(span_in) + SIZE_W'(1);
      end
      if (state_ff == ST_CHECK) begin
         status_ff <= reject ? STATUS_REJECT : STATUS_OK;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_payload_ff.status        <= status_ff;
         rsp_payload_ff.element_count <= held_ext[CAP_W-1:0];
         rsp_payload_ff.spans_valid   <= spans_valid;
         rsp_payload_ff.shortest_span <= spans_valid ? gap_ff[VALUE_W-1:0] : '0;
         rsp_payload_ff.longest_span  <= spans_valid ? VALUE_W'(largest_ff - smallest_ff) : '0;
      end
   end

   bsmm_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (icount_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsmm_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cmd     (scan_cmd),
      .count   (icount_ff),
      .stat    (scan_stat),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
